@@ rtl/cvp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvp_pkg
// Shared types, widths and constants for the camera vertex projection block.
// ----------------------------------------------------------------------------
package cvp_pkg;

  // field widths
  localparam int unsigned PW   = 24;  // Q15.8 point and camera position
  localparam int unsigned TW   = 16;  // Q1.14 sine and cosine
  localparam int unsigned FW   = 13;  // focal length in pixels
  localparam int unsigned SW   = 16;  // screen coordinate
  localparam int unsigned RW   = PW + 1;  // camera-relative offset
  localparam int unsigned XW   = 28;  // after the yaw rotation
  localparam int unsigned YW   = 31;  // after the pitch rotation
  localparam int unsigned FRAC = 14;  // fraction bits of the trig values
  localparam int unsigned QW   = 16;  // quotient bits of the projection divide
  localparam int unsigned NW   = 50;  // projection numerator
  localparam int unsigned DW   = YW + 1;  // projection divisor (2 * depth)

  localparam int unsigned QUEUE_DEPTH = 4;

  // default geometry
  localparam int unsigned DEF_SCREEN_WIDTH  = 1280;
  localparam int unsigned DEF_SCREEN_HEIGHT = 720;
  localparam int unsigned DEF_NEAR_Z        = 256;

  // register reset values
  localparam logic signed [TW-1:0] RST_COS   = 16'sd16384;
  localparam logic [FW-1:0]        RST_FOCAL = 13'd500;

  // register indexes
  typedef enum logic [2:0] {
    REG_CAM_POS_X    = 3'd0,
    REG_CAM_POS_Y    = 3'd1,
    REG_CAM_POS_Z    = 3'd2,
    REG_COS_YAW      = 3'd3,
    REG_SIN_YAW      = 3'd4,
    REG_COS_PITCH    = 3'd5,
    REG_SIN_PITCH    = 3'd6,
    REG_FOCAL_PIXELS = 3'd7
  } cvp_reg_e;

  typedef struct packed {
    logic signed [PW-1:0] point_x;
    logic signed [PW-1:0] point_y;
    logic signed [PW-1:0] point_z;
  } cvp_point_t;

  typedef struct packed {
    logic signed [SW-1:0] screen_x;
    logic signed [SW-1:0] screen_y;
    logic signed [PW-1:0] depth;
    logic                 visible;
  } cvp_result_t;

  // camera settings used by the view transform
  typedef struct packed {
    logic signed [PW-1:0] cam_pos_x;
    logic signed [PW-1:0] cam_pos_y;
    logic signed [PW-1:0] cam_pos_z;
    logic signed [TW-1:0] cos_yaw;
    logic signed [TW-1:0] sin_yaw;
    logic signed [TW-1:0] cos_pitch;
    logic signed [TW-1:0] sin_pitch;
  } cvp_cfg_t;

  // camera-space vertex handed from front to back
  typedef struct packed {
    logic signed [XW-1:0] x2;
    logic signed [YW-1:0] y2;
    logic signed [YW-1:0] z2;
    logic signed [PW-1:0] depth;
    logic                 visible;
  } cvp_view_t;

endpackage
`default_nettype wire

@@ rtl/cvp_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvp_fifo
// Short register queue between the view transform and the projection.
// ----------------------------------------------------------------------------
module cvp_fifo #(
  parameter int unsigned DEPTH = cvp_pkg::QUEUE_DEPTH
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               push_i,
  input  cvp_pkg::cvp_view_t data_i,
  input  wire               pop_i,
  output cvp_pkg::cvp_view_t data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cvp_pkg::cvp_view_t mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AW:0]   count_q, count_d;

  assign full_o  = (count_q == (AW+1)'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/cvp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvp_front
// Accepts vertices, applies the camera offset and both rotations, classifies
// visibility and pushes camera-space vertices into the queue.
// ----------------------------------------------------------------------------
module cvp_front #(
  parameter int unsigned NEAR_Z = cvp_pkg::DEF_NEAR_Z
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  cvp_pkg::cvp_cfg_t  cfg_i,
  input  wire                in_valid_i,
  input  cvp_pkg::cvp_point_t in_item_i,
  output logic               in_stall_o,
  input  wire                full_i,
  output logic               push_o,
  output cvp_pkg::cvp_view_t view_o
);

  localparam int unsigned RW = cvp_pkg::RW;
  localparam int unsigned XW = cvp_pkg::XW;
  localparam int unsigned YW = cvp_pkg::YW;
  localparam int unsigned PW = cvp_pkg::PW;
  localparam int unsigned FRAC = cvp_pkg::FRAC;
  localparam int unsigned P1W = cvp_pkg::TW + RW;  // trig * offset
  localparam int unsigned P2W = cvp_pkg::TW + XW;  // trig * yaw output
  localparam int unsigned S1W = P1W + 1;
  localparam int unsigned S2W = P2W + 1;
  localparam logic signed [S1W-1:0] Half1 = S1W'(1 << (FRAC - 1));
  localparam logic signed [S2W-1:0] Half2 = S2W'(1 << (FRAC - 1));
  localparam logic signed [YW-1:0]  NearZ = YW'(NEAR_Z);
  localparam logic signed [PW-1:0]  DepthMax = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0]  DepthMin = {1'b1, {(PW-1){1'b0}}};

  logic adv;
  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: offset from the camera
  logic signed [RW-1:0] rx_q, ry_q, rz_q;
  // stage 2: yaw products
  logic signed [P1W-1:0] cyrx_q, syrz_q, cyrz_q, syrx_q;
  logic signed [RW-1:0]  ry2_q;
  // stage 3: yaw result
  logic signed [XW-1:0] x1_q, z1_q;
  logic signed [RW-1:0] y1_q;
  // stage 4: pitch products
  logic signed [P1W-1:0] cpy1_q, spy1_q;
  logic signed [P2W-1:0] spz1_q, cpz1_q;
  logic signed [XW-1:0]  x1b_q;

  logic signed [S1W-1:0] sum_x, sum_z;
  logic signed [S2W-1:0] sum_y2, sum_z2;
  logic signed [YW-1:0]  y2, z2;

  // whole front moves together unless the queue holds back the last stage
  assign adv        = !v4_q || !full_i;
  assign in_stall_o = !adv;
  assign push_o     = v4_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // yaw rounding: floor((a + 2^13) / 2^14)
  assign sum_x = S1W'(cyrx_q) + S1W'(syrz_q) + Half1;
  assign sum_z = S1W'(cyrz_q) - S1W'(syrx_q) + Half1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rx_q   <= RW'(in_item_i.point_x) - RW'(cfg_i.cam_pos_x);
      ry_q   <= RW'(in_item_i.point_y) - RW'(cfg_i.cam_pos_y);
      rz_q   <= RW'(in_item_i.point_z) - RW'(cfg_i.cam_pos_z);
      cyrx_q <= cfg_i.cos_yaw * rx_q;
      syrz_q <= cfg_i.sin_yaw * rz_q;
      cyrz_q <= cfg_i.cos_yaw * rz_q;
      syrx_q <= cfg_i.sin_yaw * rx_q;
      ry2_q  <= ry_q;
      x1_q   <= sum_x[FRAC +: XW];
      z1_q   <= sum_z[FRAC +: XW];
      y1_q   <= ry2_q;
      cpy1_q <= cfg_i.cos_pitch * y1_q;
      spy1_q <= cfg_i.sin_pitch * y1_q;
      spz1_q <= cfg_i.sin_pitch * z1_q;
      cpz1_q <= cfg_i.cos_pitch * z1_q;
      x1b_q  <= x1_q;
    end
  end

  // pitch rounding, visibility and depth clamp
  assign sum_y2 = S2W'(cpy1_q) - S2W'(spz1_q) + Half2;
  assign sum_z2 = S2W'(spy1_q) + S2W'(cpz1_q) + Half2;
  assign y2     = sum_y2[FRAC +: YW];
  assign z2     = sum_z2[FRAC +: YW];

  always_comb begin
    view_o.x2      = x1b_q;
    view_o.y2      = y2;
    view_o.z2      = z2;
    view_o.visible = (z2 > NearZ);
    if (z2 > YW'(DepthMax)) begin
      view_o.depth = DepthMax;
    end else if (z2 < YW'(DepthMin)) begin
      view_o.depth = DepthMin;
    end else begin
      view_o.depth = z2[PW-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/cvp_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvp_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cvp_div #(
  parameter int unsigned NW = cvp_pkg::NW,
  parameter int unsigned DW = cvp_pkg::DW,
  parameter int unsigned QW = cvp_pkg::QW
) (
  input  wire          clk_i,
  input  wire          en_i,
  input  wire [NW-1:0] num_i,
  input  wire [DW-1:0] den_i,
  output logic [QW-1:0] quot_o
);

  logic [NW-1:0] rem_q  [QW];
  logic [DW-1:0] den_q  [QW];
  logic [QW-1:0] quot_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] rem_in, trial;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quot_in;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
    end

    // compare against the divisor shifted to this bit position
    assign trial = NW'(den_in) << (QW - 1 - k);
    assign ge    = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? rem_in - trial : rem_in;
        den_q[k]  <= den_in;
        quot_q[k] <= quot_in | (QW'(ge) << (QW - 1 - k));
      end
    end
  end

  assign quot_o = quot_q[QW-1];

endmodule
`default_nettype wire

@@ rtl/cvp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvp_back
// Perspective divide of camera-space vertices into saturated screen
// coordinates, with the result register facing the output channel.
// ----------------------------------------------------------------------------
module cvp_back #(
  parameter int unsigned SCREEN_WIDTH  = cvp_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = cvp_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  cvp_pkg::cvp_view_t   view_i,
  input  wire                  empty_i,
  output logic                 pop_o,
  input  wire [cvp_pkg::FW-1:0] focal_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output cvp_pkg::cvp_result_t out_item_o
);

  localparam int unsigned XW = cvp_pkg::XW;
  localparam int unsigned YW = cvp_pkg::YW;
  localparam int unsigned PW = cvp_pkg::PW;
  localparam int unsigned FW = cvp_pkg::FW;
  localparam int unsigned SW = cvp_pkg::SW;
  localparam int unsigned QW = cvp_pkg::QW;
  localparam int unsigned NW = cvp_pkg::NW;
  localparam int unsigned DW = cvp_pkg::DW;
  localparam int unsigned KW = 16;  // size + 1 constant
  localparam logic signed [KW-1:0] WidthK  = KW'(SCREEN_WIDTH + 1);
  localparam logic signed [KW-1:0] HeightK = KW'(SCREEN_HEIGHT + 1);
  localparam logic signed [SW-1:0] ScrMax  = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] ScrMin  = {1'b1, {(SW-1){1'b0}}};

  logic adv;

  // product stage
  logic                      pv_q;
  logic signed [XW+FW:0]     fx_q;
  logic signed [YW+FW:0]     fy_q;
  logic signed [YW+KW-1:0]   zw_q, zh_q;
  logic signed [YW-1:0]      z_q;
  logic signed [PW-1:0]      pdepth_q;
  logic                      pvis_q;

  // numerators biased by half the quotient range
  logic signed [NW-1:0] num_x, num_y, zbias, zlimit;
  logic                 lo_x, hi_x, lo_y, hi_y;
  logic [DW-1:0]        den;
  logic [QW-1:0]        qx, qy;

  // side band travelling with the divider
  logic              sv_q     [QW];
  logic              svis_q   [QW];
  logic [PW-1:0]     sdepth_q [QW];
  logic [3:0]        sflag_q  [QW];

  assign adv   = !sv_q[QW-1] || !out_stall_i;
  assign pop_o = adv && !empty_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fx_q     <= view_i.x2 * $signed({1'b0, focal_i});
      fy_q     <= view_i.y2 * $signed({1'b0, focal_i});
      zw_q     <= view_i.z2 * WidthK;
      zh_q     <= view_i.z2 * HeightK;
      z_q      <= view_i.z2;
      pdepth_q <= view_i.depth;
      pvis_q   <= view_i.visible;
    end
  end

  // 2*c*f + (size+1)*z + 2*z*2^15; in range when 0 <= n < 2*z*2^16
  assign zbias  = NW'(z_q) <<< 16;
  assign zlimit = NW'(z_q) <<< 17;
  assign num_x  = (NW'(fx_q) <<< 1) + NW'(zw_q) + zbias;
  assign num_y  = (NW'(fy_q) <<< 1) + NW'(zh_q) + zbias;
  assign lo_x   = num_x[NW-1];
  assign lo_y   = num_y[NW-1];
  assign hi_x   = !lo_x && (num_x >= zlimit);
  assign hi_y   = !lo_y && (num_y >= zlimit);
  assign den    = {z_q, 1'b0};

  cvp_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_x),
    .den_i (den),
    .quot_o(qx)
  );

  cvp_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (num_y),
    .den_i (den),
    .quot_o(qy)
  );

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      for (int i = 0; i < QW; i++) begin
        sv_q[i] <= 1'b0;
      end
    end else if (adv) begin
      pv_q    <= pop_o;
      sv_q[0] <= pv_q;
      for (int i = 1; i < QW; i++) begin
        sv_q[i] <= sv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      svis_q[0]   <= pvis_q;
      sdepth_q[0] <= pdepth_q;
      sflag_q[0]  <= {lo_x, hi_x, lo_y, hi_y};
      for (int i = 1; i < QW; i++) begin
        svis_q[i]   <= svis_q[i-1];
        sdepth_q[i] <= sdepth_q[i-1];
        sflag_q[i]  <= sflag_q[i-1];
      end
    end
  end

  // result formatting: unbias the quotient, clamp, blank when hidden
  always_comb begin
    out_valid_o          = sv_q[QW-1];
    out_item_o.depth     = sdepth_q[QW-1];
    out_item_o.visible   = svis_q[QW-1];
    out_item_o.screen_x  = '0;
    out_item_o.screen_y  = '0;
    if (svis_q[QW-1]) begin
      if (sflag_q[QW-1][3]) begin
        out_item_o.screen_x = ScrMin;
      end else if (sflag_q[QW-1][2]) begin
        out_item_o.screen_x = ScrMax;
      end else begin
        out_item_o.screen_x = {~qx[QW-1], qx[QW-2:0]};
      end
      if (sflag_q[QW-1][1]) begin
        out_item_o.screen_y = ScrMin;
      end else if (sflag_q[QW-1][0]) begin
        out_item_o.screen_y = ScrMax;
      end else begin
        out_item_o.screen_y = {~qy[QW-1], qy[QW-2:0]};
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/camera_vertex_project_core.sv @@
`default_nettype none
// A vertex passes 4 view stages, the queue write, the product stage and
// 16 divider stages on its way from the accepting edge to the output.
// Throughput: one vertex per cycle unless a stall holds the flow; the projection
// divider is fully pipelined (one quotient bit per stage, both axes in parallel).
// A four-entry queue between view transform and projection decouples stalls.
// Reset clears all pipeline valids, empties the queue and loads the camera
// registers with their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
// camera_vertex_project_core
// World-to-screen vertex transform: camera offset, yaw and pitch rotation,
// near-plane test and perspective projection.
// ----------------------------------------------------------------------------
module camera_vertex_project_core #(
  parameter int unsigned SCREEN_WIDTH  = cvp_pkg::DEF_SCREEN_WIDTH,
  parameter int unsigned SCREEN_HEIGHT = cvp_pkg::DEF_SCREEN_HEIGHT,
  parameter int unsigned NEAR_Z        = cvp_pkg::DEF_NEAR_Z
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  cvp_pkg::cvp_point_t  in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output cvp_pkg::cvp_result_t out_item_o,
  input  wire                  cfg_we_i,
  input  wire [2:0]            cfg_idx_i,
  input  wire [cvp_pkg::PW-1:0] cfg_data_i
);

  localparam int unsigned TW = cvp_pkg::TW;
  localparam int unsigned FW = cvp_pkg::FW;

  cvp_pkg::cvp_cfg_t  cfg_q;
  logic [FW-1:0]      focal_q;
  cvp_pkg::cvp_view_t push_data, pop_data;
  logic               push, pop, full, empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cam_pos_x <= '0;
      cfg_q.cam_pos_y <= '0;
      cfg_q.cam_pos_z <= '0;
      cfg_q.cos_yaw   <= cvp_pkg::RST_COS;
      cfg_q.sin_yaw   <= '0;
      cfg_q.cos_pitch <= cvp_pkg::RST_COS;
      cfg_q.sin_pitch <= '0;
      focal_q         <= cvp_pkg::RST_FOCAL;
    end else if (cfg_we_i) begin
      unique case (cvp_pkg::cvp_reg_e'(cfg_idx_i))
        cvp_pkg::REG_CAM_POS_X:    cfg_q.cam_pos_x <= cfg_data_i;
        cvp_pkg::REG_CAM_POS_Y:    cfg_q.cam_pos_y <= cfg_data_i;
        cvp_pkg::REG_CAM_POS_Z:    cfg_q.cam_pos_z <= cfg_data_i;
        cvp_pkg::REG_COS_YAW:      cfg_q.cos_yaw   <= cfg_data_i[TW-1:0];
        cvp_pkg::REG_SIN_YAW:      cfg_q.sin_yaw   <= cfg_data_i[TW-1:0];
        cvp_pkg::REG_COS_PITCH:    cfg_q.cos_pitch <= cfg_data_i[TW-1:0];
        cvp_pkg::REG_SIN_PITCH:    cfg_q.sin_pitch <= cfg_data_i[TW-1:0];
        cvp_pkg::REG_FOCAL_PIXELS: focal_q         <= cfg_data_i[FW-1:0];
        default: ;
      endcase
    end
  end

  cvp_front #(.NEAR_Z(NEAR_Z)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_item_i (in_item_i),
    .in_stall_o(in_stall_o),
    .full_i    (full),
    .push_o    (push),
    .view_o    (push_data)
  );

  cvp_fifo #(.DEPTH(cvp_pkg::QUEUE_DEPTH)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (pop),
    .data_o (pop_data),
    .full_o (full),
    .empty_o(empty)
  );

  cvp_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .view_i     (pop_data),
    .empty_i    (empty),
    .pop_o      (pop),
    .focal_i    (focal_q),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire

@@ rtl/cvp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvp_checker
// Port-level checks on the camera vertex projection block.
// ----------------------------------------------------------------------------
module cvp_checker (
  input wire                  clk_i,
  input wire                  rst_ni,
  input wire                  in_valid_i,
  input wire                  in_stall_o,
  input cvp_pkg::cvp_point_t  in_item_i,
  input wire                  out_valid_o,
  input wire                  out_stall_i,
  input cvp_pkg::cvp_result_t out_item_o,
  input wire                  cfg_we_i,
  input wire [2:0]            cfg_idx_i,
  input wire [cvp_pkg::PW-1:0] cfg_data_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // hidden vertices carry no screen position
  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.visible |->
      out_item_o.screen_x == '0 && out_item_o.screen_y == '0)
    else $error("hidden vertex with screen position");

  // visible vertices lie in front of the camera
  a_vis_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.visible |->
      !out_item_o.depth[cvp_pkg::PW-1] && out_item_o.depth != '0)
    else $error("visible vertex with non-positive depth");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("result straight after reset");

endmodule

bind camera_vertex_project_core cvp_checker u_cvp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_item_i  (in_item_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o),
  .cfg_we_i   (cfg_we_i),
  .cfg_idx_i  (cfg_idx_i),
  .cfg_data_i (cfg_data_i)
);
`default_nettype wire
